/* src/bpc_pkg.sv */
// bpc_pkg: shared types, constants and helper functions for the
// barometric pressure compensation pipeline; no dependencies
package bpc_pkg;

    // divider depth (one quotient bit per stage) and sideband width
    localparam int DIV_STAGES = 32;
    localparam int SIDE_W     = 64;

    // register map indexes
    localparam logic [2:0] REG_COEF_A = 3'd0;
    localparam logic [2:0] REG_COEF_B = 3'd1;
    localparam logic [2:0] REG_COEF_C = 3'd2;
    localparam logic [2:0] REG_COEF_D = 3'd3;
    localparam logic [2:0] REG_OSS    = 3'd4;

    // compensation constants
    localparam logic [31:0] C_B6_OFFSET = 32'd4000;
    localparam logic [31:0] C_P_K1      = 32'd3038;
    localparam logic [31:0] C_P_K2      = 32'hFFFF_E343; // -7357
    localparam logic [31:0] C_P_K3      = 32'd3791;
    localparam logic [31:0] C_B7_SCALE  = 32'd50000;
    localparam logic [31:0] C_B4_BIAS   = 32'd32768;

    // input word
    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } t_bpc_in;

    // result word
    typedef struct packed {
        logic signed [31:0] temperature_tenths;
        logic signed [31:0] pressure_pa;
        logic               divide_error;
    } t_bpc_out;

    // calibration set unpacked from the registers
    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } t_bpc_coef;

    // temperature stage to pressure stage
    typedef struct packed {
        logic        vld;
        logic        err;
        logic [31:0] b5;
        logic [18:0] up;
    } t_bpc_b5;

    // pressure stage to polynomial stage
    typedef struct packed {
        logic        vld;
        logic        err;
        logic [31:0] temp;
        logic [31:0] p;
    } t_bpc_pq;

    // 16-bit sign extension
    function automatic logic [31:0] f_sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // arithmetic right shift of a 32-bit word
    function automatic logic [31:0] f_asr(input logic [31:0] v, input logic [4:0] s);
        logic signed [31:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

endpackage

/* src/bpc_div.sv */
// bpc_div: pipelined 32/32 unsigned restoring divider, one quotient bit per stage
// depends on bpc_pkg
module bpc_div import bpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [31:0]       i_num,
    input  logic [31:0]       i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [31:0]       o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [DIV_STAGES];
    logic [31:0]       r_rem  [DIV_STAGES];
    logic [31:0]       r_num  [DIV_STAGES];
    logic [31:0]       r_den  [DIV_STAGES];
    logic [31:0]       r_quo  [DIV_STAGES];
    logic [SIDE_W-1:0] r_side [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic              w_vld;
        logic [31:0]       w_rem;
        logic [31:0]       w_num;
        logic [31:0]       w_den;
        logic [31:0]       w_quo;
        logic [SIDE_W-1:0] w_side;
        logic [32:0]       w_trial;
        logic              w_ge;

        // stage input: ports for the first stage, previous stage otherwise
        if (g == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = '0;
            assign w_num  = i_num;
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_num  = r_num[g-1];
            assign w_den  = r_den[g-1];
            assign w_quo  = r_quo[g-1];
            assign w_side = r_side[g-1];
        end

        // shift in next dividend bit and try the subtract
        assign w_trial = {w_rem, w_num[31]};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= w_ge ? 32'(w_trial - {1'b0, w_den}) : w_trial[31:0];
            r_num[g]  <= {w_num[30:0], 1'b0};
            r_den[g]  <= w_den;
            r_quo[g]  <= {w_quo[30:0], w_ge};
            r_side[g] <= w_side;
        end
    end

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_quo  = r_quo[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];

endmodule

/* src/bpc_temp.sv */
// bpc_temp: temperature pipeline from raw word to B5, with the signed divide
// depends on bpc_pkg and bpc_div
module bpc_temp import bpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_vld,
    input  t_bpc_in   i_item,
    input  t_bpc_coef i_coef,
    output t_bpc_b5   o_b5
);

    logic        r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic [31:0] r1_prod;
    logic [18:0] r1_up, r2_up, r3_up;
    logic [31:0] r2_x1, r2_den;
    logic [31:0] r3_x1, r3_anum, r3_aden;
    logic        r3_neg, r3_err;
    logic [31:0] r4_x1, r4_q;
    logic        r4_err;
    logic [18:0] r4_up;
    logic [31:0] r5_b5;
    logic        r5_err;
    logic [18:0] r5_up;

    logic [31:0]       w_diff, w_x1, w_num;
    logic              w_dvld;
    logic [31:0]       w_quo;
    logic [SIDE_W-1:0] w_side_in, w_side_out;

    // stage 1: (ut - ac6) * ac5
    assign w_diff = {16'd0, i_item.raw_temperature} - {16'd0, i_coef.ac6};

    // stage 2: x1 and the divisor
    assign w_x1 = f_asr(r1_prod, 5'd15);

    // stage 3: magnitudes and signs for the divide
    assign w_num = {{5{i_coef.mc[15]}}, i_coef.mc, 11'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= w_dvld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod <= w_diff * {16'd0, i_coef.ac5};
        r1_up   <= i_item.raw_pressure;
        r2_x1   <= w_x1;
        r2_den  <= w_x1 + f_sx16(i_coef.md);
        r2_up   <= r1_up;
        r3_x1   <= r2_x1;
        r3_anum <= w_num[31] ? 32'(-w_num) : w_num;
        r3_aden <= r2_den[31] ? 32'(-r2_den) : r2_den;
        r3_neg  <= w_num[31] ^ r2_den[31];
        r3_err  <= (r2_den == 32'd0);
        r3_up   <= r2_up;
    end

    // sideband: x1, quotient sign, error, raw pressure
    assign w_side_in = {r3_x1, r3_neg, r3_err, r3_up, 11'd0};

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_num   (r3_anum),
        .i_den   (r3_aden),
        .i_side  (w_side_in),
        .o_vld   (w_dvld),
        .o_quo   (w_quo),
        .o_side  (w_side_out)
    );

    // stage 4: signed quotient, stage 5: b5
    always_ff @(posedge i_clk) begin
        r4_x1  <= w_side_out[63:32];
        r4_q   <= w_side_out[31] ? 32'(-w_quo) : w_quo;
        r4_err <= w_side_out[30];
        r4_up  <= w_side_out[29:11];
        r5_b5  <= r4_x1 + r4_q;
        r5_err <= r4_err;
        r5_up  <= r4_up;
    end

    assign o_b5.vld = r5_vld;
    assign o_b5.err = r5_err;
    assign o_b5.b5  = r5_b5;
    assign o_b5.up  = r5_up;

endmodule

/* src/bpc_press.sv */
// bpc_press: pressure pipeline from B5 through B3, B4, B7 and the unsigned divide
// depends on bpc_pkg and bpc_div
module bpc_press import bpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_bpc_b5   i_b5,
    input  t_bpc_coef i_coef,
    output t_bpc_pq   o_pq
);

    localparam int NST = 9;

    // control and carried fields per stage
    logic        r_vld  [NST];
    logic        r_err  [NST];
    logic [31:0] r_temp [NST];
    logic [18:0] r_up   [NST];

    logic [31:0] r1_b6;
    logic [31:0] r2_msq, r2_ma2, r2_ma3;
    logic [31:0] r3_sq, r3_x2a, r3_x1c;
    logic [31:0] r4_mb2, r4_mb1, r4_x2a, r4_x1c;
    logic [31:0] r5_x3a, r5_x3b;
    logic [31:0] r6_b3, r6_t;
    logic [31:0] r7_mb4, r7_dd;
    logic [31:0] r8_b4, r8_b7;
    logic [31:0] r9_num, r9_den;
    logic        r9_big;
    logic        r_out_vld, r_out_err;
    logic [31:0] r_out_temp, r_out_p;

    logic [31:0]       w_sq, w_b3a, w_b3s, w_x3, w_b4;
    logic              w_dvld;
    logic [31:0]       w_quo;
    logic [SIDE_W-1:0] w_side_in, w_side_out;

    assign w_sq  = f_asr(r2_msq, 5'd12);
    assign w_b3a = (f_sx16(i_coef.ac1) << 2) + r5_x3a;
    assign w_b3s = (w_b3a << i_coef.oss) + 32'd2;
    assign w_x3  = f_asr(r5_x3b, 5'd2);
    assign w_b4  = {15'd0, r7_mb4[31:15]};

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            r_vld[0] <= i_b5.vld;
            for (int i = 1; i < NST; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_out_vld <= w_dvld;
        end
    end

    // carried fields
    always_ff @(posedge i_clk) begin
        r_err[0]  <= i_b5.err;
        r_temp[0] <= f_asr(i_b5.b5 + 32'd8, 5'd4);
        r_up[0]   <= i_b5.up;
        for (int i = 1; i < NST; i++) begin
            r_temp[i] <= r_temp[i-1];
            r_up[i]   <= r_up[i-1];
        end
        for (int i = 1; i < NST - 1; i++) begin
            r_err[i] <= r_err[i-1];
        end
        // b4 of zero flags the item
        r_err[NST-1] <= r_err[NST-2] | (r8_b4 == 32'd0);
    end

    // arithmetic stages
    always_ff @(posedge i_clk) begin
        // b6
        r1_b6  <= i_b5.b5 - C_B6_OFFSET;
        // b6 products
        r2_msq <= r1_b6 * r1_b6;
        r2_ma2 <= f_sx16(i_coef.ac2) * r1_b6;
        r2_ma3 <= f_sx16(i_coef.ac3) * r1_b6;
        // scaled terms
        r3_sq  <= w_sq;
        r3_x2a <= f_asr(r2_ma2, 5'd11);
        r3_x1c <= f_asr(r2_ma3, 5'd13);
        // sq products
        r4_mb2 <= f_sx16(i_coef.b2) * r3_sq;
        r4_mb1 <= f_sx16(i_coef.b1) * r3_sq;
        r4_x2a <= r3_x2a;
        r4_x1c <= r3_x1c;
        // x3 sums
        r5_x3a <= f_asr(r4_mb2, 5'd11) + r4_x2a;
        r5_x3b <= r4_x1c + f_asr(r4_mb1, 5'd16) + 32'd2;
        // b3 and b4 argument
        r6_b3  <= f_asr(w_b3s, 5'd2);
        r6_t   <= w_x3 + C_B4_BIAS;
        // b4 product and up - b3
        r7_mb4 <= {16'd0, i_coef.ac4} * r6_t;
        r7_dd  <= {13'd0, r_up[5]} - r6_b3;
        // b7
        r8_b4  <= w_b4;
        r8_b7  <= r7_dd * (C_B7_SCALE >> i_coef.oss);
        // dividend select
        r9_big <= r8_b7[31];
        r9_num <= r8_b7[31] ? r8_b7 : {r8_b7[30:0], 1'b0};
        r9_den <= r8_b4;
    end

    // sideband: temperature, doubling flag, error
    assign w_side_in = {r_temp[8], r9_big, r_err[8], 30'd0};

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[8]),
        .i_num   (r9_num),
        .i_den   (r9_den),
        .i_side  (w_side_in),
        .o_vld   (w_dvld),
        .o_quo   (w_quo),
        .o_side  (w_side_out)
    );

    // p, doubled after the divide for large b7
    always_ff @(posedge i_clk) begin
        r_out_temp <= w_side_out[63:32];
        r_out_err  <= w_side_out[30];
        r_out_p    <= w_side_out[31] ? {w_quo[30:0], 1'b0} : w_quo;
    end

    assign o_pq.vld  = r_out_vld;
    assign o_pq.err  = r_out_err;
    assign o_pq.temp = r_out_temp;
    assign o_pq.p    = r_out_p;

endmodule

/* src/bpc_poly.sv */
// bpc_poly: final pressure correction polynomial and error zeroing
// depends on bpc_pkg
module bpc_poly import bpc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_bpc_pq  i_pq,
    output logic     o_vld,
    output t_bpc_out o_res
);

    logic        r1_vld, r2_vld, r3_vld, r4_vld;
    logic        r1_err, r2_err, r3_err;
    logic [31:0] r1_temp, r2_temp, r3_temp;
    logic [31:0] r1_p, r2_p, r3_p;
    logic [31:0] r1_mps, r1_mc;
    logic [31:0] r2_mx1, r2_x2;
    logic [31:0] r3_sum;
    t_bpc_out    r4_res;

    logic [31:0] w_ps, w_pres;

    assign w_ps   = f_asr(i_pq.p, 5'd8);
    assign w_pres = r3_p + f_asr(r3_sum, 5'd4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_pq.vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // ps squared and p term
        r1_err  <= i_pq.err;
        r1_temp <= i_pq.temp;
        r1_p    <= i_pq.p;
        r1_mps  <= w_ps * w_ps;
        r1_mc   <= C_P_K2 * i_pq.p;
        // scale x1
        r2_err  <= r1_err;
        r2_temp <= r1_temp;
        r2_p    <= r1_p;
        r2_mx1  <= r1_mps * C_P_K1;
        r2_x2   <= f_asr(r1_mc, 5'd16);
        // correction sum
        r3_err  <= r2_err;
        r3_temp <= r2_temp;
        r3_p    <= r2_p;
        r3_sum  <= f_asr(r2_mx1, 5'd16) + r2_x2 + C_P_K3;
        // result, zeroed on a divide error
        r4_res.temperature_tenths <= r3_err ? 32'sd0 : $signed(r3_temp);
        r4_res.pressure_pa        <= r3_err ? 32'sd0 : $signed(w_pres);
        r4_res.divide_error       <= r3_err;
    end

    assign o_vld = r4_vld;
    assign o_res = r4_res;

endmodule

/* src/barometric_pressure_compensation_top.sv */
// barometric_pressure_compensation_top: register file and compensation pipeline
// depends on bpc_pkg, bpc_temp, bpc_press, bpc_poly, bpc_div
//
// channel   direction  handshake                  word
// input     in         start & !busy              i_item (t_bpc_in)
// result    out        o_valid, one cycle          o_result (t_bpc_out)
// config    in         psel & penable & pwrite    pwdata at paddr
//
// one word is taken every cycle that start is high; busy stays low
// latency is set by the two 32-stage dividers plus the multiply stages
// synchronous active-low reset clears all valid bits and loads register defaults
// the receiver cannot stall; each result shows for exactly one cycle
module barometric_pressure_compensation_top import bpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_bpc_in     i_item,
    output logic        o_valid,
    output t_bpc_out    o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [47:0] r_coef_a, r_coef_b;
    logic [31:0] r_coef_c, r_coef_d;
    logic [1:0]  r_oss;

    logic      w_wr;
    logic      w_acc;
    t_bpc_coef w_coef;
    t_bpc_b5   w_b5;
    t_bpc_pq   w_pq;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_acc  = start & ~busy;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= '0;
            r_coef_b <= '0;
            r_coef_c <= '0;
            r_coef_d <= '0;
            r_oss    <= 2'd3;
        end else if (w_wr) begin
            unique case (paddr[5:3])
                REG_COEF_A: r_coef_a <= pwdata[47:0];
                REG_COEF_B: r_coef_b <= pwdata[47:0];
                REG_COEF_C: r_coef_c <= pwdata[31:0];
                REG_COEF_D: r_coef_d <= pwdata[31:0];
                REG_OSS:    r_oss    <= pwdata[1:0];
                default:    ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[5:3])
            REG_COEF_A: prdata = {16'd0, r_coef_a};
            REG_COEF_B: prdata = {16'd0, r_coef_b};
            REG_COEF_C: prdata = {32'd0, r_coef_c};
            REG_COEF_D: prdata = {32'd0, r_coef_d};
            REG_OSS:    prdata = {62'd0, r_oss};
            default:    prdata = '0;
        endcase
    end

    // calibration unpack
    assign w_coef.ac1 = r_coef_a[47:32];
    assign w_coef.ac2 = r_coef_a[31:16];
    assign w_coef.ac3 = r_coef_a[15:0];
    assign w_coef.ac4 = r_coef_b[47:32];
    assign w_coef.ac5 = r_coef_b[31:16];
    assign w_coef.ac6 = r_coef_b[15:0];
    assign w_coef.b1  = r_coef_c[31:16];
    assign w_coef.b2  = r_coef_c[15:0];
    assign w_coef.mc  = r_coef_d[31:16];
    assign w_coef.md  = r_coef_d[15:0];
    assign w_coef.oss = r_oss;

    bpc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_acc),
        .i_item  (i_item),
        .i_coef  (w_coef),
        .o_b5    (w_b5)
    );

    bpc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_b5    (w_b5),
        .i_coef  (w_coef),
        .o_pq    (w_pq)
    );

    bpc_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pq    (w_pq),
        .o_vld   (o_valid),
        .o_res   (o_result)
    );

    // checks
    a_no_valid_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.divide_error) |->
            (o_result.temperature_tenths == 0 && o_result.pressure_pa == 0))
        else $error("divide error word carries nonzero results");

    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pq.vld |=> ##3 o_valid)
        else $error("polynomial stage lost a word");

endmodule
